### rtl/stuis_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table search package
// Field widths, request codes and the queued command record shared by the
// front end, the command queue and the search engine.
// ----------------------------------------------------------------------------
package stuis_pkg;

   // Widths of the channel fields.
   localparam int ENTRY_INDEX_WIDTH = 10;
   localparam int KEY_VALUE_WIDTH   = 32;
   localparam int FOUND_INDEX_WIDTH = 10;
   localparam int TABLE_SIZE_WIDTH  = 11;

   // Widest key the engine supports; request keys are sign-extended to it.
   localparam int KEY_EXT_WIDTH = 64;

   // Table size after reset.
   localparam logic [TABLE_SIZE_WIDTH-1:0] TABLE_SIZE_RESET = 11'd1024;

   // Entries in the queue between the front end and the search engine.
   localparam int QUEUE_DEPTH = 2;

   // Request action codes.
   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   // One classified request as it waits in the queue.
   typedef struct packed {
      action_type                   action;
      logic [ENTRY_INDEX_WIDTH-1:0] entry_index;
      logic [KEY_VALUE_WIDTH-1:0]   key_value;
   } cmd_type;

endpackage

### rtl/stuis_if.sv
// ----------------------------------------------------------------------------
// Sorted table search channels
// Valid/ready channels for requests, responses and the table size register.
// ----------------------------------------------------------------------------

// Request channel: table writes and queries.
interface stuis_req_if import stuis_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [ENTRY_INDEX_WIDTH-1:0] entry_index;
   logic [KEY_VALUE_WIDTH-1:0]   key_value;

   modport source (output valid, output action, output entry_index, output key_value,
                   input ready);
   modport sink   (input valid, input action, input entry_index, input key_value,
                   output ready);
endinterface

// Response channel: one index per query.
interface stuis_rsp_if import stuis_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [FOUND_INDEX_WIDTH-1:0] found_index;

   modport source (output valid, output found_index, input ready);
   modport sink   (input valid, input found_index, output ready);
endinterface

// Register write channel: the table size.
interface stuis_csr_if import stuis_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [TABLE_SIZE_WIDTH-1:0] table_size;

   modport source (output valid, output table_size, input ready);
   modport sink   (input valid, input table_size, output ready);
endinterface

### rtl/stuis_front.sv
// ----------------------------------------------------------------------------
// Sorted table search front end
// Accepts requests, drops writes that fall outside the table and hands the
// rest to the command queue.
// ----------------------------------------------------------------------------
module stuis_front import stuis_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   stuis_req_if.sink  req_chan,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    push_cmd
);

   logic in_range;
   logic take;

   // A request is taken whenever the queue has room.
   assign req_chan.ready = !queue_full;
   assign take           = req_chan.valid && req_chan.ready;

   // Writes beyond the table depth are swallowed here.
   assign in_range = (32'(req_chan.entry_index) < 32'(TABLE_DEPTH));

   always_comb begin
      push_cmd.action      = action_type'(req_chan.action);
      push_cmd.entry_index = req_chan.entry_index;
      push_cmd.key_value   = req_chan.key_value;
      push = take && ((push_cmd.action == ACT_QUERY) || in_range);
   end

endmodule

### rtl/stuis_queue.sv
// ----------------------------------------------------------------------------
// Sorted table search command queue
// Small FIFO that decouples the front end from the search engine.
// ----------------------------------------------------------------------------
module stuis_queue import stuis_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    not_empty,
   input  logic    pop,
   output cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots need no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/stuis_back.sv
// ----------------------------------------------------------------------------
// Sorted table search engine
// Holds the key table and the size register, carries out writes and runs
// the end checks and the bisection for queries, one memory read per step.
// ----------------------------------------------------------------------------
module stuis_back import stuis_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_WIDTH   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         queue_not_empty,
   input  cmd_type      queue_cmd,
   output logic         queue_pop,
   stuis_rsp_if.source  rsp_chan,
   stuis_csr_if.sink    csr_chan
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK_TOP,
      ST_CHECK_BOTTOM,
      ST_PROBE,
      ST_EMIT
   } state_type;

   // Key table, written and read through one port each.
   logic signed [KEY_WIDTH-1:0] table_mem [TABLE_DEPTH];
   logic signed [KEY_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]            rd_addr;
   logic                        wr_en;

   state_type                     state_ff, state_in;
   logic signed [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [IDX_W-1:0]              lo_ff, lo_in;
   logic [IDX_W-1:0]              hi_ff, hi_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [FOUND_INDEX_WIDTH-1:0]  rsp_index_ff, rsp_index_in;
   logic [TABLE_SIZE_WIDTH-1:0]   size_ff, size_in;

   logic [KEY_EXT_WIDTH-1:0]      key_ext;
   logic signed [KEY_WIDTH-1:0]   cmd_key;
   logic [IDX_W-1:0]              last_idx;
   logic [IDX_W-1:0]              probe_mid;
   logic [IDX_W-1:0]              next_lo;
   logic [IDX_W-1:0]              next_hi;

   function automatic logic [IDX_W-1:0] midpoint(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[IDX_W:1];
   endfunction

   // True once the interval is at most one step wide.
   function automatic logic interval_done(input logic [IDX_W-1:0] lo,
                                          input logic [IDX_W-1:0] hi);
      return ({1'b0, hi} <= ({1'b0, lo} + (IDX_W + 1)'(1)));
   endfunction

   // Request key, sign-extended and cut to the table key width.
   assign key_ext = {{(KEY_EXT_WIDTH - KEY_VALUE_WIDTH){queue_cmd.key_value[KEY_VALUE_WIDTH-1]}},
                     queue_cmd.key_value};
   assign cmd_key = key_ext[KEY_WIDTH-1:0];

   // Last index in use: a size of zero counts as one, sizes above the depth saturate.
   always_comb begin
      if (size_ff == '0) begin
         last_idx = '0;
      end else if (32'(size_ff) > 32'(TABLE_DEPTH)) begin
         last_idx = IDX_W'(TABLE_DEPTH - 1);
      end else begin
         last_idx = IDX_W'(size_ff - TABLE_SIZE_WIDTH'(1));
      end
   end

   // Bisection step on the entry read at the current midpoint.
   always_comb begin
      probe_mid = midpoint(lo_ff, hi_ff);
      next_lo   = lo_ff;
      next_hi   = hi_ff;
      if (key_ff > rd_data_ff) begin
         next_lo = probe_mid;
      end else begin
         next_hi = probe_mid;
      end
   end

   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found_index = rsp_index_ff;

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      size_in      = size_ff;
      queue_pop    = 1'b0;
      wr_en        = 1'b0;
      rd_addr      = '0;

      if (csr_chan.valid) begin
         size_in = csr_chan.table_size;
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (queue_not_empty) begin
               queue_pop = 1'b1;
               if (queue_cmd.action == ACT_WRITE) begin
                  wr_en = 1'b1;
               end else begin
                  key_in   = cmd_key;
                  lo_in    = '0;
                  hi_in    = last_idx;
                  rd_addr  = last_idx;
                  state_in = ST_CHECK_TOP;
               end
            end
         end
         ST_CHECK_TOP: begin
            // At or above the last entry: the answer is the last index.
            if (key_ff >= rd_data_ff) begin
               state_in = ST_EMIT;
            end else begin
               rd_addr  = '0;
               state_in = ST_CHECK_BOTTOM;
            end
         end
         ST_CHECK_BOTTOM: begin
            if (key_ff <= rd_data_ff) begin
               hi_in    = '0;
               state_in = ST_EMIT;
            end else if (interval_done(lo_ff, hi_ff)) begin
               state_in = ST_EMIT;
            end else begin
               rd_addr  = midpoint(lo_ff, hi_ff);
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            lo_in = next_lo;
            hi_in = next_hi;
            if (interval_done(next_lo, next_hi)) begin
               state_in = ST_EMIT;
            end else begin
               rd_addr = midpoint(next_lo, next_hi);
            end
         end
         ST_EMIT: begin
            // The upper end holds the answer; wait for a free response slot.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = FOUND_INDEX_WIDTH'(hi_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         size_ff      <= TABLE_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         size_ff      <= size_in;
      end
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rsp_index_ff <= rsp_index_in;
   end

   // Table memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[IDX_W'(queue_cmd.entry_index)] <= cmd_key;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

endmodule

### rtl/sorted_table_upper_index_search_top.sv
// ----------------------------------------------------------------------------
// Sorted table upper index search
// Ascending key table with a bisection search that returns the index of the
// smallest entry at or above a query key, clamped to the table ends.
//
//   Channel  | Direction | Payload                              | Handshake
//   ---------+-----------+--------------------------------------+------------
//   req_chan | in        | action, entry_index, key_value       | valid/ready
//   rsp_chan | out       | found_index (one per query)          | valid/ready
//   csr_chan | in        | table_size                           | valid/ready
//
// A write is done in the idle state of the search engine. A query checks the
// last entry, then entry 0, then bisects between them; each probe is one read.
// Reset clears control state and sets the table size to 1024; the table holds
// nothing until written. A two-entry queue takes requests during a search, and
// the response register holds a result while the next request is worked on.
// ----------------------------------------------------------------------------
module sorted_table_upper_index_search_top import stuis_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   stuis_req_if.sink   req_chan,
   stuis_rsp_if.source rsp_chan,
   stuis_csr_if.sink   csr_chan
);

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_not_empty;
   logic    queue_pop;
   cmd_type queue_cmd;

   // Request intake and classification.
   stuis_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Queue between intake and the search engine.
   stuis_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (queue_pop),
      .pop_cmd   (queue_cmd)
   );

   // Table storage and search sequencer.
   stuis_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_cmd       (queue_cmd),
      .queue_pop       (queue_pop),
      .rsp_chan        (rsp_chan),
      .csr_chan        (csr_chan)
   );

endmodule

### rtl/stuis_checker.sv
// ----------------------------------------------------------------------------
// Sorted table search port checker
// Watches the top level ports: responses only answer queries, stay within
// the table in use and hold while stalled.
// ----------------------------------------------------------------------------
module stuis_checker import stuis_pkg::*; #(
   parameter int TABLE_DEPTH = 1024
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_action,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [FOUND_INDEX_WIDTH-1:0] rsp_found_index,
   input logic                         csr_valid,
   input logic                         csr_ready,
   input logic [TABLE_SIZE_WIDTH-1:0]  csr_table_size
);

   logic [3:0]                  pending_ff, pending_in;
   logic [TABLE_SIZE_WIDTH-1:0] size_ff, size_in;
   logic [31:0]                 used_entries;
   logic                        query_taken;
   logic                        rsp_taken;

   assign query_taken = req_valid && req_ready && (action_type'(req_action) == ACT_QUERY);
   assign rsp_taken   = rsp_valid && rsp_ready;

   // Count of queries still owed a response, and the table size in force.
   always_comb begin
      pending_in = pending_ff;
      if (query_taken && !rsp_taken) begin
         pending_in = pending_ff + 4'd1;
      end else if (rsp_taken && !query_taken) begin
         pending_in = pending_ff - 4'd1;
      end
      size_in = (csr_valid && csr_ready) ? csr_table_size : size_ff;
      if (size_ff == '0) begin
         used_entries = 32'd1;
      end else if (32'(size_ff) > 32'(TABLE_DEPTH)) begin
         used_entries = 32'(TABLE_DEPTH);
      end else begin
         used_entries = 32'(size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         size_ff    <= TABLE_SIZE_RESET;
      end else begin
         pending_ff <= pending_in;
         size_ff    <= size_in;
      end
   end

   // No response is shown in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Every response answers an earlier query; writes never produce one.
   assert property (@(posedge clock) disable iff (reset) rsp_taken |-> (pending_ff != '0))
      else $error("response without an outstanding query");

   // The answer lies within the entries in use.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> (32'(rsp_found_index) < used_entries))
      else $error("found index beyond the table in use");

   // A stalled response holds its index.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_index))
      else $error("stalled response changed");

endmodule

bind sorted_table_upper_index_search_top stuis_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_stuis_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_action      (req_chan.action),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_found_index (rsp_chan.found_index),
   .csr_valid       (csr_chan.valid),
   .csr_ready       (csr_chan.ready),
   .csr_table_size  (csr_chan.table_size)
);
